FILE: src/celi_pkg.sv
// ----------------------------------------------------------------------------
// celi_pkg
// shared widths, types and codes for the cell edge coverage pipeline
// ----------------------------------------------------------------------------
package celi_pkg;

    localparam int COORD_W  = 32;   // signed q16.16 coordinates
    localparam int LEN_W    = 24;   // unsigned q8.16 radius and cell side
    localparam int OUT_W    = 26;   // unsigned q10.16 covered length
    localparam int CLASS_W  = 2;
    localparam int LANES    = 4;    // one lane per cell edge
    localparam int POS_W    = 31;   // chord centre along an edge, doubled units
    localparam int SQ_W     = 57;   // squared corner offset, doubled units
    localparam int RAD_W    = 50;   // radicand r^2 - p^2
    localparam int ROOT_W   = RAD_W / 2;
    localparam int CHORD_W  = LEN_W + 1;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [LEN_W-1:0] CELL_SIZE_RESET = LEN_W'(65536);

    // register index taken from paddr word bits
    localparam logic [PADDR_W-3:0] REG_CELL_SIZE = '0;

    typedef enum logic [CLASS_W-1:0] {
        COV_FAR     = 2'd0,
        COV_PARTIAL = 2'd1,
        COV_FULL    = 2'd2
    } cov_class_t;

    // per item data that rides alongside the edge lanes
    typedef struct packed {
        logic                         far_hit;
        logic                         full_hit;
        logic [LEN_W-1:0]             side;
        logic [LANES-1:0]             hit;
        logic [LANES-1:0][POS_W-1:0]  pos;
    } celi_side_t;

endpackage

FILE: src/celi_geom.sv
// ----------------------------------------------------------------------------
// celi_geom
// corner distances, far and full classification, chord radicands (4 stages)
// ----------------------------------------------------------------------------
module celi_geom
(
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic [celi_pkg::LEN_W-1:0]                        cell_size,
    input  logic                                              in_valid,
    output logic                                              in_ready,
    input  logic signed [celi_pkg::COORD_W-1:0]               particle_x,
    input  logic signed [celi_pkg::COORD_W-1:0]               particle_y,
    input  logic signed [celi_pkg::COORD_W-1:0]               cell_x,
    input  logic signed [celi_pkg::COORD_W-1:0]               cell_y,
    input  logic [celi_pkg::LEN_W-1:0]                        radius,
    output logic                                              out_valid,
    input  logic                                              out_ready,
    output celi_pkg::celi_side_t                              out_side,
    output logic [celi_pkg::LANES-1:0][celi_pkg::RAD_W-1:0]   out_rad
);

    localparam int N   = 4;
    localparam int XW  = 30;
    localparam int SQW = celi_pkg::SQ_W;
    localparam int RW  = celi_pkg::RAD_W;
    localparam int LW  = celi_pkg::LEN_W;
    localparam int PW  = celi_pkg::POS_W;
    localparam int COORD_W_C = celi_pkg::COORD_W + 1;

    logic [N-1:0] v_reg;
    logic [N-1:0] en;

    // stage 1
    logic signed [XW-1:0]    x1_reg, y1_reg;
    logic                    far1_reg;
    logic [LW:0]             rr1_reg;
    logic [LW-1:0]           s1_reg;
    logic [LW+1:0]           lim1_reg;
    logic signed [COORD_W_C-1:0] dx, dy;

    // stage 2
    logic [SQW-1:0]          ax0_reg, ax1_reg, ay0_reg, ay1_reg;
    logic [RW-1:0]           r2_2_reg;
    logic [2*LW+3:0]         lim2_2_reg;
    logic                    far2_reg;
    logic [LW-1:0]           s2_reg;
    logic [3:0][PW-1:0]      pos2_reg;
    logic signed [XW-1:0]    sx, xm, xp, ym, yp;
    logic signed [2*XW-1:0]  pxm, pxp, pym, pyp;
    logic signed [PW-1:0]    xs, ys, s31;

    // stage 3
    logic [SQW-1:0]          minx_reg, maxx_reg, miny_reg, maxy_reg;
    logic [RW-1:0]           r2_3_reg;
    logic [2*LW+3:0]         lim2_3_reg;
    logic                    far3_reg;
    logic [LW-1:0]           s3_reg;
    logic [3:0][PW-1:0]      pos3_reg;
    logic [3:0]              hit3_reg;
    logic [3:0][RW-1:0]      rad3_reg;
    logic [3:0][SQW-1:0]     p2;

    // stage 4
    logic [SQW:0]            dmin, dmax;

    always_comb
    begin
        en[N-1] = !v_reg[N-1] || out_ready;
        for (int k = N - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[N-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < N; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage 1: centre offset in doubled units, far check on the raw offset
    always_comb
    begin
        dx = COORD_W_C'(cell_x) - COORD_W_C'(particle_x);
        dy = COORD_W_C'(cell_y) - COORD_W_C'(particle_y);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x1_reg   <= {dx[XW-2:0], 1'b0};
            y1_reg   <= {dy[XW-2:0], 1'b0};
            far1_reg <= (dx > COORD_W_C'(134217728)) || (dx < -COORD_W_C'(134217728))
                     || (dy > COORD_W_C'(134217728)) || (dy < -COORD_W_C'(134217728));
            rr1_reg  <= {radius, 1'b0};
            s1_reg   <= cell_size;
            lim1_reg <= {1'b0, radius, 1'b0} + {1'b0, cell_size, 1'b0};
        end
    end

    // stage 2: the four distinct corner offsets squared
    always_comb
    begin
        sx  = $signed({{(XW-LW){1'b0}}, s1_reg});
        xm  = x1_reg - sx;
        xp  = x1_reg + sx;
        ym  = y1_reg - sx;
        yp  = y1_reg + sx;
        pxm = xm * xm;
        pxp = xp * xp;
        pym = ym * ym;
        pyp = yp * yp;
        xs  = PW'(x1_reg);
        ys  = PW'(y1_reg);
        s31 = $signed({{(PW-LW){1'b0}}, s1_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ax0_reg    <= pxm[SQW-1:0];
            ax1_reg    <= pxp[SQW-1:0];
            ay0_reg    <= pym[SQW-1:0];
            ay1_reg    <= pyp[SQW-1:0];
            r2_2_reg   <= rr1_reg * rr1_reg;
            lim2_2_reg <= lim1_reg * lim1_reg;
            far2_reg   <= far1_reg;
            s2_reg     <= s1_reg;
            pos2_reg[0] <= s31 - xs;
            pos2_reg[1] <= s31 - ys;
            pos2_reg[2] <= xs + s31;
            pos2_reg[3] <= ys + s31;
        end
    end

    // stage 3: per-axis min and max, edge radicands
    always_comb
    begin
        p2[0] = ay0_reg;
        p2[1] = ax1_reg;
        p2[2] = ay1_reg;
        p2[3] = ax0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            minx_reg   <= (ax0_reg < ax1_reg) ? ax0_reg : ax1_reg;
            maxx_reg   <= (ax0_reg < ax1_reg) ? ax1_reg : ax0_reg;
            miny_reg   <= (ay0_reg < ay1_reg) ? ay0_reg : ay1_reg;
            maxy_reg   <= (ay0_reg < ay1_reg) ? ay1_reg : ay0_reg;
            r2_3_reg   <= r2_2_reg;
            lim2_3_reg <= lim2_2_reg;
            far3_reg   <= far2_reg;
            s3_reg     <= s2_reg;
            pos3_reg   <= pos2_reg;
            for (int e = 0; e < 4; e++)
            begin
                hit3_reg[e] <= SQW'(r2_2_reg) > p2[e];
                rad3_reg[e] <= r2_2_reg - p2[e][RW-1:0];
            end
        end
    end

    // stage 4: nearest and farthest corner against the two bounds
    always_comb
    begin
        dmin = {1'b0, minx_reg} + {1'b0, miny_reg};
        dmax = {1'b0, maxx_reg} + {1'b0, maxy_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            out_side.far_hit  <= far3_reg || (dmin > (SQW+1)'(lim2_3_reg));
            out_side.full_hit <= dmax < (SQW+1)'(r2_3_reg);
            out_side.side     <= s3_reg;
            out_side.hit      <= hit3_reg;
            out_side.pos      <= pos3_reg;
            out_rad           <= rad3_reg;
        end
    end

endmodule

FILE: src/celi_sqrt.sv
// ----------------------------------------------------------------------------
// celi_sqrt
// four-lane floor square root, one result bit per pipeline stage
// ----------------------------------------------------------------------------
module celi_sqrt
(
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               in_valid,
    output logic                                               in_ready,
    input  celi_pkg::celi_side_t                               in_side,
    input  logic [celi_pkg::LANES-1:0][celi_pkg::RAD_W-1:0]    in_rad,
    output logic                                               out_valid,
    input  logic                                               out_ready,
    output celi_pkg::celi_side_t                               out_side,
    output logic [celi_pkg::LANES-1:0][celi_pkg::ROOT_W-1:0]   out_root
);

    localparam int N  = celi_pkg::ROOT_W;
    localparam int RW = celi_pkg::RAD_W;
    localparam int QW = celi_pkg::ROOT_W;
    localparam int NL = celi_pkg::LANES;

    logic [N-1:0] v_reg;
    logic [N-1:0] en;

    logic [NL-1:0][RW-1:0]  rem_reg  [N];
    logic [NL-1:0][QW-1:0]  q_reg    [N];
    celi_pkg::celi_side_t   side_reg [N];

    always_comb
    begin
        en[N-1] = !v_reg[N-1] || out_ready;
        for (int k = N - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[N-1];
    assign out_side  = side_reg[N-1];
    assign out_root  = q_reg[N-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < N; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        localparam int B = N - 1 - k;

        logic [NL-1:0][RW-1:0]  rem_in;
        logic [NL-1:0][QW-1:0]  q_in;
        celi_pkg::celi_side_t   side_in;
        logic [NL-1:0][RW-1:0]  rem_nx;
        logic [NL-1:0][QW-1:0]  q_nx;
        logic [RW+1:0]          trial [NL];

        if (k == 0)
        begin : g_first
            assign rem_in  = in_rad;
            assign q_in    = '0;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // try setting bit B: (q + 2^B)^2 - q^2 = q*2^(B+1) + 2^(2B)
        always_comb
        begin
            for (int l = 0; l < NL; l++)
            begin
                trial[l] = ((RW+2)'(q_in[l]) << (B + 1)) + ((RW+2)'(1) << (2 * B));
                if ((RW+2)'(rem_in[l]) >= trial[l])
                begin
                    rem_nx[l] = rem_in[l] - trial[l][RW-1:0];
                    q_nx[l]   = q_in[l] | (QW'(1) << B);
                end
                else
                begin
                    rem_nx[l] = rem_in[l];
                    q_nx[l]   = q_in[l];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k]  <= rem_nx;
                q_reg[k]    <= q_nx;
                side_reg[k] <= side_in;
            end
        end
    end

endmodule

FILE: src/celi_finish.sv
// ----------------------------------------------------------------------------
// celi_finish
// chord clipping, sum, rounding, saturation and class select (3 stages)
// ----------------------------------------------------------------------------
module celi_finish
(
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               in_valid,
    output logic                                               in_ready,
    input  celi_pkg::celi_side_t                               in_side,
    input  logic [celi_pkg::LANES-1:0][celi_pkg::ROOT_W-1:0]   in_root,
    output logic                                               out_valid,
    input  logic                                               out_ready,
    output logic [celi_pkg::OUT_W-1:0]                         covered_length,
    output celi_pkg::cov_class_t                               coverage_class
);

    localparam int N  = 3;
    localparam int NL = celi_pkg::LANES;
    localparam int DW = 32;
    localparam int CW = celi_pkg::CHORD_W;
    localparam int LW = celi_pkg::LEN_W;
    localparam int OW = celi_pkg::OUT_W;
    localparam int SW = CW + 2;

    logic [N-1:0] v_reg;
    logic [N-1:0] en;

    logic signed [DW-1:0]   lo_reg [NL];
    logic signed [DW-1:0]   hi_reg [NL];
    celi_pkg::celi_side_t   side1_reg;
    logic [NL-1:0][CW-1:0]  chord_reg;
    logic                   far2_reg, full2_reg;
    logic [LW-1:0]          s2_reg;

    logic signed [DW-1:0]   lo_raw [NL];
    logic signed [DW-1:0]   hi_raw [NL];
    logic signed [DW-1:0]   edge_len;
    logic signed [DW-1:0]   diff [NL];
    logic [SW-1:0]          sum;
    logic [OW-1:0]          half, four_s;

    always_comb
    begin
        en[N-1] = !v_reg[N-1] || out_ready;
        for (int k = N - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[N-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < N; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage 1: chord ends clipped to the edge
    always_comb
    begin
        edge_len = $signed({{(DW-LW-1){1'b0}}, in_side.side, 1'b0});
        for (int l = 0; l < NL; l++)
        begin
            lo_raw[l] = DW'($signed(in_side.pos[l])) - $signed(DW'(in_root[l]));
            hi_raw[l] = DW'($signed(in_side.pos[l])) + $signed(DW'(in_root[l]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            side1_reg <= in_side;
            for (int l = 0; l < NL; l++)
            begin
                lo_reg[l] <= (lo_raw[l] < 0) ? '0 : lo_raw[l];
                hi_reg[l] <= (hi_raw[l] > edge_len) ? edge_len : hi_raw[l];
            end
        end
    end

    // stage 2: clipped chord length per edge
    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            diff[l] = hi_reg[l] - lo_reg[l];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            far2_reg  <= side1_reg.far_hit;
            full2_reg <= side1_reg.full_hit;
            s2_reg    <= side1_reg.side;
            for (int l = 0; l < NL; l++)
            begin
                chord_reg[l] <= (side1_reg.hit[l] && (hi_reg[l] > lo_reg[l]))
                              ? diff[l][CW-1:0] : '0;
            end
        end
    end

    // stage 3: halve with round half up, saturate, pick class
    always_comb
    begin
        sum = SW'(1);
        for (int l = 0; l < NL; l++)
        begin
            sum = sum + SW'(chord_reg[l]);
        end
        half   = sum[SW-1:1];
        four_s = {s2_reg, 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            if (far2_reg)
            begin
                covered_length <= '0;
                coverage_class <= celi_pkg::COV_FAR;
            end
            else if (full2_reg)
            begin
                covered_length <= four_s;
                coverage_class <= celi_pkg::COV_FULL;
            end
            else
            begin
                covered_length <= (half > four_s) ? four_s : half;
                coverage_class <= celi_pkg::COV_PARTIAL;
            end
        end
    end

endmodule

FILE: src/cell_edge_length_inside_circle_core.sv
// ----------------------------------------------------------------------------
// cell_edge_length_inside_circle_core
// length of a square cell's edges lying inside a particle's circle
// ----------------------------------------------------------------------------
// pipeline: 4 geometry stages, then 25 square root stages at one root bit
//   each, then 3 clip and sum stages
// throughput: one item per cycle unless m_tready stalls it, every stage
//   has its own valid bit and a stalled output only holds occupied stages
// reset: rst_n clears all valid bits at once, cell_size returns to 1.0
// ----------------------------------------------------------------------------
module cell_edge_length_inside_circle_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    // apb style configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [celi_pkg::PADDR_W-1:0]    paddr,
    input  logic [celi_pkg::PDATA_W-1:0]    pwdata,
    output logic [celi_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // particle_x, particle_y, cell_x, cell_y, radius
    input  logic [151:0]                    s_tdata,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // covered_length, zero fill
    output logic [31:0]                     m_tdata,
    // coverage_class
    output logic [1:0]                      m_tuser
);

    localparam int LW = celi_pkg::LEN_W;

    logic [LW-1:0]  cell_size_reg;
    logic           cfg_sel;

    // geometry to square root
    logic                                                   g_valid, g_ready;
    celi_pkg::celi_side_t                                   g_side;
    logic [celi_pkg::LANES-1:0][celi_pkg::RAD_W-1:0]        g_rad;

    // square root to finish
    logic                                                   q_valid, q_ready;
    celi_pkg::celi_side_t                                   q_side;
    logic [celi_pkg::LANES-1:0][celi_pkg::ROOT_W-1:0]       q_root;

    logic [celi_pkg::OUT_W-1:0]                             covered_length;
    celi_pkg::cov_class_t                                   coverage_class;

    // register file, single word at byte address 0
    assign cfg_sel = paddr[celi_pkg::PADDR_W-1:2] == celi_pkg::REG_CELL_SIZE;
    assign pready  = 1'b1;
    assign prdata  = cfg_sel ? celi_pkg::PDATA_W'(cell_size_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg <= celi_pkg::CELL_SIZE_RESET;
        end
        else if (psel && penable && pwrite && pready && cfg_sel)
        begin
            cell_size_reg <= pwdata[LW-1:0];
        end
    end

    // corner distances and classification
    celi_geom u_geom
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_size  (cell_size_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .particle_x (s_tdata[31:0]),
        .particle_y (s_tdata[63:32]),
        .cell_x     (s_tdata[95:64]),
        .cell_y     (s_tdata[127:96]),
        .radius     (s_tdata[151:128]),
        .out_valid  (g_valid),
        .out_ready  (g_ready),
        .out_side   (g_side),
        .out_rad    (g_rad)
    );

    // half chord of each edge
    celi_sqrt u_sqrt
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (g_valid),
        .in_ready   (g_ready),
        .in_side    (g_side),
        .in_rad     (g_rad),
        .out_valid  (q_valid),
        .out_ready  (q_ready),
        .out_side   (q_side),
        .out_root   (q_root)
    );

    // clip, sum and output register
    celi_finish u_finish
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (q_valid),
        .in_ready       (q_ready),
        .in_side        (q_side),
        .in_root        (q_root),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .covered_length (covered_length),
        .coverage_class (coverage_class)
    );

    assign m_tdata = {{(32-celi_pkg::OUT_W){1'b0}}, covered_length};
    assign m_tuser = coverage_class;

`ifndef SYNTH
    // a draining output never holds back the input
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    // far items carry no length
    a_far_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == celi_pkg::COV_FAR) |-> (m_tdata == '0))
        else $error("far item with non-zero length");

    // full coverage is four whole sides
    a_full_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == celi_pkg::COV_FULL) |-> (m_tdata[1:0] == 2'b00))
        else $error("full coverage not a multiple of four");

    // no unused class code leaves the block
    a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != 2'd3))
        else $error("bad coverage class");
`endif

endmodule

FILE: tb/sv/tb_cell_edge_length_inside_circle_core.sv
// ----------------------------------------------------------------------------
// tb_cell_edge_length_inside_circle_core
// self-checking bench for the cell edge coverage pipeline: directed table
// then random circles around cells under several cell sizes, every result
// checked in order of arrival against its typed-in answer or an in-bench
// predictor
module tb_cell_edge_length_inside_circle_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LAT = 32;

    // one expected result
    typedef struct {
        logic [celi_pkg::OUT_W-1:0] length;
        celi_pkg::cov_class_t       cls;
    } cover_t;

    // directed row: fields plus optional typed-in answer
    typedef struct {
        logic [31:0]                px;
        logic [31:0]                py;
        logic [31:0]                cx;
        logic [31:0]                cy;
        logic [celi_pkg::LEN_W-1:0] rad;
        bit                         known;
        logic [celi_pkg::OUT_W-1:0] length;
        celi_pkg::cov_class_t       cls;
    } row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [celi_pkg::PADDR_W-1:0]   paddr;
    logic [celi_pkg::PDATA_W-1:0]   pwdata;
    logic [celi_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [151:0]                   s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [31:0]                    m_tdata;
    logic [1:0]                     m_tuser;

    cover_t                         cover_q[$];
    int                             errors;
    logic [celi_pkg::LEN_W-1:0]     side_reg;

    cell_edge_length_inside_circle_core u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // integer floor square root
    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // clipped chord of one edge, doubled units
    function automatic longint edge_chord(longint p, longint u, longint len,
                                          longint unsigned r2);
        longint unsigned p2;
        longint h;
        longint lo;
        longint hi;
        p2 = longint'(p * p);
        if (r2 <= p2)
            return 0;
        h = longint'(floor_root(r2 - p2));
        lo = u - h;
        hi = u + h;
        if (lo < 0)
            lo = 0;
        if (hi > len)
            hi = len;
        return (hi > lo) ? hi - lo : 0;
    endfunction

    function automatic longint abs_l(longint a);
        return (a < 0) ? -a : a;
    endfunction

    // edge coverage of one circle against the current cell
    function automatic cover_t cover_of(logic [31:0] px, logic [31:0] py,
                                        logic [31:0] cx, logic [31:0] cy,
                                        logic [celi_pkg::LEN_W-1:0] rad);
        cover_t          c;
        longint          r;
        longint          s;
        longint          l;
        longint          x;
        longint          y;
        longint          kx[4];
        longint          ky[4];
        longint unsigned d2;
        longint unsigned dmin;
        longint unsigned dmax;
        longint unsigned lim;
        longint unsigned r2;
        longint unsigned res;
        longint          total;
        c.length = '0;
        c.cls    = celi_pkg::COV_FAR;
        r = longint'(rad) * 2;
        s = longint'(side_reg);
        l = 2 * s;
        x = 2 * (longint'($signed(cx)) - longint'($signed(px)));
        y = 2 * (longint'($signed(cy)) - longint'($signed(py)));
        if (abs_l(x) > (64'sd1 <<< 28) || abs_l(y) > (64'sd1 <<< 28))
            return c;
        kx[0] = x - s; ky[0] = y - s;
        kx[1] = x + s; ky[1] = y - s;
        kx[2] = x + s; ky[2] = y + s;
        kx[3] = x - s; ky[3] = y + s;
        dmin = 0;
        dmax = 0;
        for (int k = 0; k < 4; k++)
        begin
            d2 = longint'(kx[k] * kx[k]) + longint'(ky[k] * ky[k]);
            if (k == 0 || d2 < dmin)
                dmin = d2;
            if (k == 0 || d2 > dmax)
                dmax = d2;
        end
        lim = r + l;
        if (dmin > lim * lim)
            return c;
        r2 = r * r;
        if (dmax < r2)
        begin
            c.length = celi_pkg::OUT_W'(4 * s);
            c.cls    = celi_pkg::COV_FULL;
            return c;
        end
        total = edge_chord(abs_l(y - s), s - x, l, r2)
              + edge_chord(abs_l(x + s), s - y, l, r2)
              + edge_chord(abs_l(y + s), x + s, l, r2)
              + edge_chord(abs_l(x - s), y + s, l, r2);
        res = (longint'(total) + 1) >> 1;
        if (res > 4 * s)
            res = 4 * s;
        c.length = celi_pkg::OUT_W'(res);
        c.cls    = celi_pkg::COV_PARTIAL;
        return c;
    endfunction

    // apb write, setup then access phase
    task automatic write_cell_size(logic [celi_pkg::LEN_W-1:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= celi_pkg::PADDR_W'({celi_pkg::REG_CELL_SIZE, 2'b00});
        pwdata  <= celi_pkg::PDATA_W'(v);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        side_reg = v;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // input idle, wait for drained pipe, then latency margin
    task automatic drain();
        s_tvalid <= 1'b0;
        while (cover_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    // one input transfer, with random gap before it; valid stays up after
    // the transfer so that back to back items keep it high
    task automatic send_circle(logic [31:0] px, logic [31:0] py, logic [31:0] cx,
                               logic [31:0] cy, logic [celi_pkg::LEN_W-1:0] rad,
                               bit known, cover_t want);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {rad, cy, cx, py, px};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        if (known)
            cover_q = {cover_q, want};
        else
            cover_q = {cover_q, cover_of(px, py, cx, cy, rad)};
        @(negedge clk);
    endtask

    // result side: check each accepted result against oldest expectation
    always @(posedge clk)
    begin
        cover_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cover_q.size() == 0)
            begin
                $display("%0t unexpected result: actual length %0d class %0d",
                         $time, m_tdata[celi_pkg::OUT_W-1:0], m_tuser);
                errors++;
            end
            else
            begin
                want = cover_q.pop_front();
                if (m_tdata[celi_pkg::OUT_W-1:0] !== want.length
                    || m_tdata[31:celi_pkg::OUT_W] !== '0)
                begin
                    $display("%0t length mismatch: expected %0d actual %0d",
                             $time, want.length, m_tdata);
                    errors++;
                end
                if (m_tuser !== want.cls)
                begin
                    $display("%0t class mismatch: expected %0d actual %0d",
                             $time, want.cls, m_tuser);
                    errors++;
                end
            end
        end
    end

    // stall pattern drawn per result, with quiet stretches
    initial
    begin
        int stall;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
        end
    end

    initial
    begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

    // random circle near the current cell, or raw noise
    task automatic send_random();
        logic [31:0]                px;
        logic [31:0]                py;
        logic [31:0]                cx;
        logic [31:0]                cy;
        logic [celi_pkg::LEN_W-1:0] rad;
        int                         mode;
        int                         span;
        cover_t                     none;
        none.length = '0;
        none.cls    = celi_pkg::COV_FAR;
        mode = $urandom_range(0, 9);
        cx = $urandom();
        cy = $urandom();
        if (mode == 0)
        begin
            // raw noise
            px  = $urandom();
            py  = $urandom();
            rad = $urandom();
        end
        else
        begin
            span = (mode < 3) ? 28 : (mode < 6) ? 20 : 17;
            rad  = celi_pkg::LEN_W'($urandom()
                   >> (32 - ((mode < 3) ? 24 : (mode < 6) ? 20 : 18)));
            px = cx + 32'($signed($urandom() >> (32 - span)) - (1 <<< (span - 1)));
            py = cy + 32'($signed($urandom() >> (32 - span)) - (1 <<< (span - 1)));
        end
        send_circle(px, py, cx, cy, rad, 1'b0, none);
    endtask

    initial
    begin
        row_t                       rows[$];
        row_t                       r;
        cover_t                     want;
        logic [celi_pkg::LEN_W-1:0] sizes[6];
        errors       = 0;
        side_reg     = celi_pkg::CELL_SIZE_RESET;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows, unit cell after reset
        rows = '{
            // far away: offset beyond bound
            '{32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 24'hFF_FFFF, 1, 26'd0,
              celi_pkg::COV_FAR},
            '{32'h0, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 24'd0, 1, 26'd0,
              celi_pkg::COV_FAR},
            // fully inside: centred large circle
            '{32'h0, 32'h0, 32'h0, 32'h0, 24'hFF_FFFF, 1, 26'd262144,
              celi_pkg::COV_FULL},
            '{32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h1, 24'h02_0000, 1, 26'd262144,
              celi_pkg::COV_FULL},
            // zero radius on the centre
            '{32'h0, 32'h0, 32'h0, 32'h0, 24'd0, 1, 26'd0, celi_pkg::COV_PARTIAL},
            // circle inscribed, tangent to every edge
            '{32'h0, 32'h0, 32'h0, 32'h0, 24'h00_8000, 0, 26'd0, celi_pkg::COV_FAR},
            // circumscribed, corners on the circle
            '{32'h0, 32'h0, 32'h0, 32'h0, 24'h00_B505, 0, 26'd0, celi_pkg::COV_FAR},
            '{32'h0, 32'h0, 32'h0, 32'h0, 24'h00_B504, 0, 26'd0, celi_pkg::COV_FAR},
            // corner centred, partial
            '{32'h0000_8000, 32'h0000_8000, 32'h0, 32'h0, 24'h00_4000, 0, 26'd0,
              celi_pkg::COV_FAR},
            // just at the far boundary
            '{32'h0, 32'h0, 32'h0002_0000, 32'h0, 24'h00_8000, 0, 26'd0,
              celi_pkg::COV_FAR},
            '{32'h0, 32'h0, 32'h0800_0000, 32'h0, 24'hFF_FFFF, 0, 26'd0,
              celi_pkg::COV_FAR},
            '{32'h0, 32'h0, 32'h0800_0001, 32'h0, 24'hFF_FFFF, 0, 26'd0,
              celi_pkg::COV_FAR},
            '{32'h0, 32'h0, 32'hF800_0000, 32'hF800_0000, 24'hFF_FFFF, 0, 26'd0,
              celi_pkg::COV_FAR},
            // edge only, then patterned fields on a centred circle
            '{32'h0, 32'h0001_0000, 32'h0, 32'h0, 24'h00_C000, 0, 26'd0,
              celi_pkg::COV_FAR},
            '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 24'hAA_AAAA,
              0, 26'd0, celi_pkg::COV_FAR}
        };
        foreach (rows[i])
        begin
            r = rows[i];
            want.length = r.length;
            want.cls    = r.cls;
            send_circle(r.px, r.py, r.cx, r.cy, r.rad, r.known, want);
        end
        drain();

        // cell size phases, extremes included
        sizes = '{24'd1, 24'hFF_FFFF, 24'h00_4000, 24'h03_0000, 24'h55_5555, 24'h01_0000};
        foreach (sizes[i])
        begin
            write_cell_size(sizes[i]);
            for (int n = 0; n < 225; n++)
            begin
                send_random();
                // hold-off until the pipe has emptied
                if (n == 100)
                begin
                    s_tvalid <= 1'b0;
                    while (cover_q.size() != 0)
                        @(posedge clk);
                    @(negedge clk);
                end
            end
            drain();
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
src/celi_pkg.sv
src/celi_geom.sv
src/celi_sqrt.sv
src/celi_finish.sv
src/cell_edge_length_inside_circle_core.sv
tb/sv/tb_cell_edge_length_inside_circle_core.sv
